// ===== rtl/core/cat_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cat_pkg
// Shared types and constants for the client address table: request and
// status codes, controller states and the structs that run along the cells.
// ----------------------------------------------------------------------------
package cat_pkg;

    localparam int DEF_TABLE_SLOTS = 16;
    localparam int SLOT_W          = 6;
    localparam int IP_W            = 32;
    localparam int PORT_W          = 16;
    localparam int KEY_W           = IP_W + PORT_W;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_LOOKUP = 2'd2,
        REQ_LIST   = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_ADDED     = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_FULL      = 3'd2,
        ST_REMOVED   = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_FOUND     = 3'd5,
        ST_EMPTY     = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DONE,
        S_LIST
    } t_state;

    // Running search results handed from one cell to the next
    typedef struct packed {
        logic              hit_seen;
        logic [SLOT_W-1:0] hit_slot;
        logic              free_seen;
        logic [SLOT_W-1:0] free_slot;
        logic              list_seen;
        logic              list_more;
        logic [SLOT_W-1:0] list_slot;
        logic [KEY_W-1:0]  list_key;
    } t_chain;

    // Command broadcast to every cell
    typedef struct packed {
        logic [KEY_W-1:0]  match_key;
        logic [SLOT_W-1:0] list_idx;
        logic              wr_en;
        logic              wr_clear;
        logic [SLOT_W-1:0] wr_slot;
        logic [KEY_W-1:0]  wr_key;
    } t_cell_cmd;

endpackage
`default_nettype wire

// ===== rtl/core/cat_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cat_cell
// One table slot: holds a key and its valid mark, compares against the
// broadcast key and merges its own match, free and listing results into
// the chain passed on to the next slot.
// ----------------------------------------------------------------------------
module cat_cell #(
    parameter int SLOT_ID = 0
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  cat_pkg::t_cell_cmd i_cmd,
    input  cat_pkg::t_chain    i_chain,
    output cat_pkg::t_chain    o_chain
);

    localparam logic [cat_pkg::SLOT_W-1:0] MY_SLOT = cat_pkg::SLOT_W'(SLOT_ID);

    logic                      r_valid;
    logic [cat_pkg::KEY_W-1:0] r_key;

    logic match;
    logic hit_sel;
    logic free_sel;
    logic in_range;
    logic list_sel;

    // Update the slot on a write aimed at it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.wr_en && i_cmd.wr_slot == MY_SLOT) begin
            r_valid <= !i_cmd.wr_clear;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && i_cmd.wr_slot == MY_SLOT) begin
            r_key <= i_cmd.wr_clear ? '0 : i_cmd.wr_key;
        end
    end

    // Local compare and first-come selection along the chain
    always_comb begin
        match    = r_valid && (r_key == i_cmd.match_key);
        hit_sel  = match && !i_chain.hit_seen;
        free_sel = !r_valid && !i_chain.free_seen;
        in_range = r_valid && (MY_SLOT >= i_cmd.list_idx);
        list_sel = in_range && !i_chain.list_seen;

        o_chain.hit_seen  = i_chain.hit_seen | match;
        o_chain.hit_slot  = i_chain.hit_slot | (hit_sel ? MY_SLOT : '0);
        o_chain.free_seen = i_chain.free_seen | !r_valid;
        o_chain.free_slot = i_chain.free_slot | (free_sel ? MY_SLOT : '0);
        o_chain.list_seen = i_chain.list_seen | in_range;
        o_chain.list_more = i_chain.list_more | (in_range && i_chain.list_seen);
        o_chain.list_slot = i_chain.list_slot | (list_sel ? MY_SLOT : '0);
        o_chain.list_key  = i_chain.list_key | (list_sel ? r_key : '0);
    end

endmodule
`default_nettype wire

// ===== rtl/core/client_address_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// client_address_table
// Table of endpoint keys (IPv4 address and port) built as a row of slot
// cells. Handles add, remove, lookup and listing of all valid entries.
// ----------------------------------------------------------------------------
//  Channel   Direction  tdata                               tuser        tlast
//  s_axis    in         ip[31:0] port[47:32]                req_type     -
//  m_axis    out        slot[5:0] ip[37:6] port[53:38]      status       last
//
//  Add, remove and lookup match the key against all slots through the cell
//  chain in the accept cycle; the result is issued and the table written
//  from the done state once the output register is free.
//  A listing returns one result per valid entry, or one empty reply.
//  One request is in flight at a time; a result waiting in the output
//  register does not block accepting the next request.
//  Reset clears all valid marks.
// ----------------------------------------------------------------------------
module client_address_table #(
    parameter int TABLE_SLOTS = cat_pkg::DEF_TABLE_SLOTS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [47:0] s_axis_tdata,   // client_ip[31:0], client_port[47:32]
    input  wire  [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [55:0] m_axis_tdata,   // slot[5:0], entry_ip[37:6], entry_port[53:38]
    output logic [2:0]  m_axis_tuser,   // status[2:0]
    output logic        m_axis_tlast
);

    localparam int SW = cat_pkg::SLOT_W;
    localparam int KW = cat_pkg::KEY_W;

    cat_pkg::t_state    r_state, n_state;
    cat_pkg::t_req      r_req;
    logic [KW-1:0]      r_key;
    logic               r_hit;
    logic [SW-1:0]      r_hit_slot;
    logic               r_free;
    logic [SW-1:0]      r_free_slot;
    logic [SW-1:0]      r_idx, n_idx;

    logic               r_out_valid;
    cat_pkg::t_status   r_out_status, n_out_status;
    logic [SW-1:0]      r_out_slot, n_out_slot;
    logic [KW-1:0]      r_out_key, n_out_key;
    logic               r_out_last, n_out_last;
    logic               load_out;
    logic               out_free;
    logic               accept;
    logic [KW-1:0]      in_key;

    cat_pkg::t_cell_cmd cmd;
    cat_pkg::t_chain    links [TABLE_SLOTS+1];

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    // Hold keys with the address in the upper bits and the port below
    assign in_key = {s_axis_tdata[cat_pkg::IP_W-1:0], s_axis_tdata[KW-1:cat_pkg::IP_W]};

    // Cell row
    assign links[0] = '0;

    for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
        cat_cell #(
            .SLOT_ID (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_chain (links[g]),
            .o_chain (links[g+1])
        );
    end

    // Controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cat_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the request and its match results on a transaction
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req       <= cat_pkg::t_req'(s_axis_tuser);
            r_key       <= in_key;
            r_hit       <= links[TABLE_SLOTS].hit_seen;
            r_hit_slot  <= links[TABLE_SLOTS].hit_slot;
            r_free      <= links[TABLE_SLOTS].free_seen;
            r_free_slot <= links[TABLE_SLOTS].free_slot;
        end
        r_idx <= n_idx;
    end

    // Next state, table writes and result selection
    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        load_out      = 1'b0;
        n_out_status  = cat_pkg::ST_NOT_FOUND;
        n_out_slot    = '0;
        n_out_key     = '0;
        n_out_last    = 1'b1;
        s_axis_tready = 1'b0;

        cmd.match_key = in_key;
        cmd.list_idx  = r_idx;
        cmd.wr_en     = 1'b0;
        cmd.wr_clear  = 1'b0;
        cmd.wr_slot   = '0;
        cmd.wr_key    = r_key;

        case (r_state)
            cat_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_idx = '0;
                    if (cat_pkg::t_req'(s_axis_tuser) == cat_pkg::REQ_LIST) begin
                        n_state = cat_pkg::S_LIST;
                    end else begin
                        n_state = cat_pkg::S_DONE;
                    end
                end
            end
            cat_pkg::S_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = cat_pkg::S_IDLE;
                    case (r_req)
                        cat_pkg::REQ_ADD: begin
                            if (r_hit) begin
                                n_out_status = cat_pkg::ST_PRESENT;
                                n_out_slot   = r_hit_slot;
                                n_out_key    = r_key;
                            end else if (r_free) begin
                                n_out_status = cat_pkg::ST_ADDED;
                                n_out_slot   = r_free_slot;
                                n_out_key    = r_key;
                                cmd.wr_en    = 1'b1;
                                cmd.wr_slot  = r_free_slot;
                            end else begin
                                n_out_status = cat_pkg::ST_FULL;
                            end
                        end
                        cat_pkg::REQ_REMOVE: begin
                            if (r_hit) begin
                                n_out_status = cat_pkg::ST_REMOVED;
                                n_out_slot   = r_hit_slot;
                                n_out_key    = r_key;
                                cmd.wr_en    = 1'b1;
                                cmd.wr_clear = 1'b1;
                                cmd.wr_slot  = r_hit_slot;
                            end
                        end
                        cat_pkg::REQ_LOOKUP: begin
                            if (r_hit) begin
                                n_out_status = cat_pkg::ST_FOUND;
                                n_out_slot   = r_hit_slot;
                                n_out_key    = r_key;
                            end
                        end
                        default: begin
                            n_out_status = cat_pkg::ST_NOT_FOUND;
                        end
                    endcase
                end
            end
            cat_pkg::S_LIST: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (links[TABLE_SLOTS].list_seen) begin
                        n_out_status = cat_pkg::ST_FOUND;
                        n_out_slot   = links[TABLE_SLOTS].list_slot;
                        n_out_key    = links[TABLE_SLOTS].list_key;
                        n_out_last   = !links[TABLE_SLOTS].list_more;
                        n_idx        = links[TABLE_SLOTS].list_slot + SW'(1);
                        if (!links[TABLE_SLOTS].list_more) begin
                            n_state = cat_pkg::S_IDLE;
                        end
                    end else begin
                        // Nothing valid from the first slot on: empty table
                        n_out_status = cat_pkg::ST_EMPTY;
                        n_state      = cat_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = cat_pkg::S_IDLE;
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_status <= n_out_status;
            r_out_slot   <= n_out_slot;
            r_out_key    <= n_out_key;
            r_out_last   <= n_out_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {2'b00, r_out_key[cat_pkg::PORT_W-1:0],
                            r_out_key[KW-1:cat_pkg::PORT_W], r_out_slot};

endmodule
`default_nettype wire

// ===== tb/client_address_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// client_address_table_tb
// Drives add, remove, lookup and list requests into the endpoint table and
// checks every reply against a table model kept inside the testbench.
// Directed tests cover the empty table, the all-zero and all-one keys and a
// full table; random traffic over a small key pool follows, with random
// gaps and stalls on both streams in all but one of its runs.
// ----------------------------------------------------------------------------
module client_address_table_tb;

    localparam int SLOTS     = cat_pkg::DEF_TABLE_SLOTS;
    localparam int POOL_SIZE = 24;
    localparam int TAIL_CYC  = 40;
    localparam int SW        = cat_pkg::SLOT_W;
    localparam int KW        = cat_pkg::KEY_W;
    localparam int PW        = cat_pkg::PORT_W;

    // One reply of the table
    typedef struct packed {
        cat_pkg::t_status        status;
        logic [SW-1:0]           slot;
        logic [cat_pkg::IP_W-1:0] ip;
        logic [PW-1:0]           port;
        logic                    last;
    } t_table_reply;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;   // client_ip[31:0], client_port[47:32]
    logic [1:0]  s_axis_tuser  = '0;   // req_type[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [55:0] m_axis_tdata;         // slot[5:0], entry_ip[37:6], entry_port[53:38]
    logic [2:0]  m_axis_tuser;         // status[2:0]
    logic        m_axis_tlast;

    // Table model
    logic [KW-1:0] model_key   [SLOTS];
    logic          model_valid [SLOTS];

    t_table_reply  pending_replies [$];
    logic [KW-1:0] key_pool [POOL_SIZE];
    bit            idle_en = 1'b0;
    int            rx_wait = 0;
    int            error_count = 0;

    client_address_table #(
        .TABLE_SLOTS(SLOTS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop in case the table hangs
    initial begin
        #5_000_000;
        $display("client_address_table test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------
    task automatic push_reply(input cat_pkg::t_status st, input int slot,
                              input logic [KW-1:0] key, input logic last);
        t_table_reply r;
        r.status = st;
        r.slot   = slot[SW-1:0];
        r.ip     = key[KW-1:PW];
        r.port   = key[PW-1:0];
        r.last   = last;
        pending_replies.push_back(r);
    endtask

    // Apply one accepted request to the model and queue its replies
    task automatic predict_request(input cat_pkg::t_req req, input logic [KW-1:0] key);
        int hit;
        int free_idx;
        int final_idx;
        hit       = -1;
        free_idx  = -1;
        final_idx = -1;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (model_valid[s] && model_key[s] == key) hit = s;
            if (!model_valid[s]) free_idx = s;
        end
        for (int s = 0; s < SLOTS; s++) begin
            if (model_valid[s]) final_idx = s;
        end
        case (req)
            cat_pkg::REQ_ADD: begin
                if (hit >= 0) begin
                    push_reply(cat_pkg::ST_PRESENT, hit, model_key[hit], 1'b1);
                end else if (free_idx < 0) begin
                    push_reply(cat_pkg::ST_FULL, 0, '0, 1'b1);
                end else begin
                    model_key[free_idx]   = key;
                    model_valid[free_idx] = 1'b1;
                    push_reply(cat_pkg::ST_ADDED, free_idx, key, 1'b1);
                end
            end
            cat_pkg::REQ_REMOVE: begin
                if (hit < 0) begin
                    push_reply(cat_pkg::ST_NOT_FOUND, 0, '0, 1'b1);
                end else begin
                    push_reply(cat_pkg::ST_REMOVED, hit, model_key[hit], 1'b1);
                    model_key[hit]   = '0;
                    model_valid[hit] = 1'b0;
                end
            end
            cat_pkg::REQ_LOOKUP: begin
                if (hit < 0) push_reply(cat_pkg::ST_NOT_FOUND, 0, '0, 1'b1);
                else push_reply(cat_pkg::ST_FOUND, hit, model_key[hit], 1'b1);
            end
            default: begin
                if (final_idx < 0) begin
                    push_reply(cat_pkg::ST_EMPTY, 0, '0, 1'b1);
                end else begin
                    for (int s = 0; s < SLOTS; s++) begin
                        if (model_valid[s]) begin
                            push_reply(cat_pkg::ST_FOUND, s, model_key[s], s == final_idx);
                        end
                    end
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    task automatic send_request(input cat_pkg::t_req req, input logic [KW-1:0] key);
        int gap;
        gap = idle_en ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {key[PW-1:0], key[KW-1:PW]};
        s_axis_tuser  <= req;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        predict_request(req, key);
    endtask

    // Hold requests back until every reply is in
    task automatic drain_replies();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_replies.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Reply side: stall for a random count after each transaction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (m_axis_tvalid === 1'b1 && m_axis_tready) rx_wait = idle_en ? $urandom_range(0, 14) : 0;
        if (rx_wait > 0) begin
            m_axis_tready <= 1'b0;
            rx_wait--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic void check_field(input string name, input logic [47:0] exp_val,
                                        input logic [47:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_val, act_val);
            error_count++;
        end
    endfunction

    // Compare each reply transaction with the oldest expected reply
    always @(posedge i_clk) begin
        t_table_reply exp_r;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected reply, expected none actual status %0d slot %0d",
                         $time, m_axis_tuser, m_axis_tdata[5:0]);
                error_count++;
            end else begin
                exp_r = pending_replies.pop_front();
                check_field("status", exp_r.status, m_axis_tuser);
                check_field("slot", exp_r.slot, m_axis_tdata[5:0]);
                check_field("entry_ip", exp_r.ip, m_axis_tdata[37:6]);
                check_field("entry_port", exp_r.port, m_axis_tdata[53:38]);
                check_field("last", exp_r.last, m_axis_tlast);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_empty_table();
        send_request(cat_pkg::REQ_LIST, key_pool[0]);
        send_request(cat_pkg::REQ_LOOKUP, key_pool[0]);
        send_request(cat_pkg::REQ_REMOVE, key_pool[1]);
    endtask

    // All-zero and all-one keys, duplicate add, reuse of a freed slot
    task automatic test_key_extremes();
        send_request(cat_pkg::REQ_ADD, '0);
        send_request(cat_pkg::REQ_ADD, '1);
        send_request(cat_pkg::REQ_ADD, '1);
        send_request(cat_pkg::REQ_LOOKUP, '0);
        send_request(cat_pkg::REQ_REMOVE, '0);
        send_request(cat_pkg::REQ_ADD, key_pool[POOL_SIZE-1]);
    endtask

    // Fill every slot, overflow once, then list the whole table
    task automatic test_full_table();
        for (int i = 0; i < SLOTS - 2; i++) send_request(cat_pkg::REQ_ADD, key_pool[i]);
        send_request(cat_pkg::REQ_ADD, key_pool[SLOTS]);
        send_request(cat_pkg::REQ_LIST, '0);
    endtask

    task automatic test_random_traffic(input int count, input bit with_idle);
        int            pick;
        cat_pkg::t_req req;
        logic [47:0]   key;
        idle_en = with_idle;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) req = cat_pkg::REQ_ADD;
            else if (pick < 65) req = cat_pkg::REQ_REMOVE;
            else if (pick < 90) req = cat_pkg::REQ_LOOKUP;
            else req = cat_pkg::REQ_LIST;
            if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else key = {$urandom(), 16'($urandom())};
            send_request(req, key);
        end
    endtask

    initial begin
        for (int s = 0; s < SLOTS; s++) begin
            model_key[s]   = '0;
            model_valid[s] = 1'b0;
        end
        for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = {$urandom(), 16'($urandom())};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_en = 1'b1;
        test_empty_table();
        test_key_extremes();
        test_full_table();
        drain_replies();

        test_random_traffic(35, 1'b1);
        test_random_traffic(30, 1'b0);
        drain_replies();
        test_random_traffic(40, 1'b1);

        drain_replies();
        repeat (TAIL_CYC) @(posedge i_clk);
        if (error_count == 0 && pending_replies.size() == 0) begin
            $display("client_address_table test passed");
        end else begin
            $display("client_address_table test failed");
        end
        $finish;
    end

endmodule
